@@ hw/rtl/ffra_pkg.sv @@
// Shared types, widths and constants of the frame-fenced ring allocator.
// Used by the channel interfaces and every module of the block; depends on nothing.
package ffra_pkg;

  // Width of a ring offset (head, tail, slot ends, slice offset).
  localparam int OFFSET_BITS = 24;
  // Capacity and byte counts need one bit more to hold the full ring size.
  localparam int CAP_W = OFFSET_BITS + 1;
  // Request size and alignment fields.
  localparam int SIZE_W = 25;
  // Frame slot field.
  localparam int SLOT_W = 3;
  // Opcode field.
  localparam int OP_W = 2;
  // Shared adder width: aligned head plus size stays below 2^(OFFSET_BITS+3).
  localparam int ALU_W = OFFSET_BITS + 3;

  localparam int DEFAULT_FRAME_SLOTS = 8;
  localparam int DEFAULT_ALIGN = 16;

  localparam logic [CAP_W-1:0] CAP_MAX = CAP_W'(1) << OFFSET_BITS;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_MAX;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC   = 2'd0,
    OP_RECORD  = 2'd1,
    OP_RELEASE = 2'd2,
    OP_NOP     = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_A_SIZE,
    S_A_OFF,
    S_A_END,
    S_A_HT,
    S_A_FIT,
    S_A_WRAP,
    S_R_CMP,
    S_R_DIV,
    S_U_HT,
    S_U_WRAP,
    S_U_ADD,
    S_FREE,
    S_OUT
  } state_t;

  // Request to the shared add/subtract unit.
  typedef struct packed {
    logic             sub;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } alu_req_t;

  // Result of the shared unit: value, borrow of a subtraction, and zero flag.
  typedef struct packed {
    logic [ALU_W-1:0] res;
    logic             borrow;
    logic             zero;
  } alu_rsp_t;

endpackage

@@ hw/rtl/ffra_req_if.sv @@
// Request channel of the ring allocator: valid/ready plus the request fields.
// Depends on ffra_pkg for the field widths.
interface ffra_req_if;
  import ffra_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [SIZE_W-1:0] request_size;
  logic [SIZE_W-1:0] align_bytes;
  logic [SLOT_W-1:0] frame_slot;

  modport source (output valid, output opcode, output request_size, output align_bytes,
                  output frame_slot, input ready);
  modport sink (input valid, input opcode, input request_size, input align_bytes,
                input frame_slot, output ready);
endinterface

@@ hw/rtl/ffra_rsp_if.sv @@
// Result channel of the ring allocator: valid/ready plus the result fields.
// Depends on ffra_pkg for the field widths.
interface ffra_rsp_if;
  import ffra_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   granted;
  logic [OFFSET_BITS-1:0] slice_offset;
  logic [CAP_W-1:0]       used_bytes;
  logic [CAP_W-1:0]       free_bytes;
  logic                   ring_empty;

  modport source (output valid, output granted, output slice_offset, output used_bytes,
                  output free_bytes, output ring_empty, input ready);
  modport sink (input valid, input granted, input slice_offset, input used_bytes,
                input free_bytes, input ring_empty, output ready);
endinterface

@@ hw/rtl/ffra_alu.sv @@
// Shared add/subtract unit of the ring allocator, used at most once per sequencer step.
// Depends on ffra_pkg for the request and result structs.
module ffra_alu (
  input  ffra_pkg::alu_req_t req,
  output ffra_pkg::alu_rsp_t rsp
);
  import ffra_pkg::*;

  logic [ALU_W:0] sum;

  // One extra bit catches the borrow of a subtraction.
  always_comb begin
    if (req.sub) begin
      sum = {1'b0, req.a} - {1'b0, req.b};
    end else begin
      sum = {1'b0, req.a} + {1'b0, req.b};
    end
  end

  assign rsp.res    = sum[ALU_W-1:0];
  assign rsp.borrow = req.sub & sum[ALU_W];
  assign rsp.zero   = (sum[ALU_W-1:0] == '0);

endmodule

@@ hw/rtl/ffra_seq.sv @@
// Sequencer and state of the ring allocator: head, tail, slot ends, result register.
// Depends on ffra_pkg, ffra_req_if, ffra_rsp_if; drives the shared ffra_alu.
module ffra_seq #(
  parameter int FRAME_SLOTS = ffra_pkg::DEFAULT_FRAME_SLOTS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [ffra_pkg::CAP_W-1:0] cap,
  ffra_req_if.sink                  req,
  ffra_rsp_if.source                rsp,
  output ffra_pkg::alu_req_t        alu_req,
  input  ffra_pkg::alu_rsp_t        alu_rsp
);
  import ffra_pkg::*;

  localparam int IDX_W = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
  localparam int EXT_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
  localparam int CNT_W = $clog2(OFFSET_BITS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(OFFSET_BITS - 1);

  state_t state, state_next;

  // Ring state.
  logic [OFFSET_BITS-1:0] head, head_next;
  logic [OFFSET_BITS-1:0] tail, tail_next;
  logic [OFFSET_BITS-1:0] slot_end [FRAME_SLOTS];

  // Per-transaction working registers.
  logic [SIZE_W-1:0]      size_r, size_next;
  logic [SIZE_W-1:0]      am1_r, am1_next;
  logic [ALU_W-1:0]       off_r, off_next;
  logic [ALU_W-1:0]       end_r, end_next;
  logic                   ht_ge_r, ht_ge_next;
  logic [OFFSET_BITS-1:0] t_r, t_next;
  logic [OFFSET_BITS-1:0] rem_r, rem_next;
  logic [CNT_W-1:0]       cnt_r, cnt_next;
  logic [CAP_W-1:0]       used_r, used_next;
  logic [CAP_W-1:0]       free_r, free_next;
  logic                   granted_r, granted_next;
  logic [OFFSET_BITS-1:0] offset_r, offset_next;

  // Result register.
  logic rsp_valid;
  logic rsp_load;

  logic                   accept;
  op_t                    op_in;
  logic                   slot_ok_in;
  logic [EXT_W-1:0]       slot_ext;
  logic [IDX_W-1:0]       idx_in;
  logic                   record_wr;
  logic [OFFSET_BITS:0]   div_shift;
  logic                   empty_flag;

  assign op_in      = op_t'(req.opcode);
  assign slot_ext   = EXT_W'(req.frame_slot);
  assign idx_in     = slot_ext[IDX_W-1:0];
  assign slot_ok_in = int'(req.frame_slot) < FRAME_SLOTS;
  assign accept     = req.valid & req.ready;
  assign record_wr  = accept && (op_in == OP_RECORD) && slot_ok_in;
  assign div_shift  = {rem_r, t_r[OFFSET_BITS-1]};

  always_comb begin
    empty_flag = (head == tail);
    for (int i = 0; i < FRAME_SLOTS; i++) begin
      if (slot_end[i] != tail) begin
        empty_flag = 1'b0;
      end
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (op_in)
            OP_ALLOC:   state_next = S_A_SIZE;
            OP_RELEASE: state_next = slot_ok_in ? S_R_CMP : S_U_HT;
            default:    state_next = S_U_HT;
          endcase
        end
      end
      S_A_SIZE: state_next = (size_r == '0 || alu_rsp.borrow) ? S_U_HT : S_A_OFF;
      S_A_OFF:  state_next = S_A_END;
      S_A_END:  state_next = S_A_HT;
      S_A_HT:   state_next = S_A_FIT;
      S_A_FIT:  state_next = (ht_ge_r && alu_rsp.borrow) ? S_A_WRAP : S_U_HT;
      S_A_WRAP: state_next = S_U_HT;
      S_R_CMP:  state_next = alu_rsp.borrow ? S_U_HT : S_R_DIV;
      S_R_DIV:  state_next = (cnt_r == CNT_LAST) ? S_U_HT : S_R_DIV;
      S_U_HT:   state_next = (alu_rsp.zero || !alu_rsp.borrow) ? S_FREE : S_U_WRAP;
      S_U_WRAP: state_next = S_U_ADD;
      S_U_ADD:  state_next = S_FREE;
      S_FREE:   state_next = S_OUT;
      S_OUT:    state_next = (!rsp_valid || rsp.ready) ? S_IDLE : S_OUT;
      default:  state_next = S_IDLE;
    endcase
  end

  // Outputs: shared unit operands and datapath updates.
  always_comb begin
    alu_req      = '0;
    head_next    = head;
    tail_next    = tail;
    size_next    = size_r;
    am1_next     = am1_r;
    off_next     = off_r;
    end_next     = end_r;
    ht_ge_next   = ht_ge_r;
    t_next       = t_r;
    rem_next     = rem_r;
    cnt_next     = cnt_r;
    used_next    = used_r;
    free_next    = free_r;
    granted_next = granted_r;
    offset_next  = offset_r;
    rsp_load     = 1'b0;
    req.ready    = (state == S_IDLE);

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          size_next    = req.request_size;
          am1_next     = (req.align_bytes == '0) ? SIZE_W'(DEFAULT_ALIGN - 1)
                                                  : req.align_bytes - SIZE_W'(1);
          t_next       = slot_end[idx_in];
          granted_next = ((op_in == OP_RECORD) || (op_in == OP_RELEASE)) && slot_ok_in;
          offset_next  = '0;
          used_next    = '0;
        end
      end
      S_A_SIZE: begin
        alu_req.sub = 1'b1;
        alu_req.a   = ALU_W'(cap);
        alu_req.b   = ALU_W'(size_r);
      end
      S_A_OFF: begin
        alu_req.a = ALU_W'(head);
        alu_req.b = ALU_W'(am1_r);
        off_next  = alu_rsp.res & ~ALU_W'(am1_r);
      end
      S_A_END: begin
        alu_req.a = off_r;
        alu_req.b = ALU_W'(size_r);
        end_next  = alu_rsp.res;
      end
      S_A_HT: begin
        alu_req.sub = 1'b1;
        alu_req.a   = ALU_W'(head);
        alu_req.b   = ALU_W'(tail);
        ht_ge_next  = !alu_rsp.borrow;
      end
      S_A_FIT: begin
        alu_req.sub = 1'b1;
        alu_req.a   = ht_ge_r ? ALU_W'(cap) : ALU_W'(tail);
        alu_req.b   = end_r;
        if (!alu_rsp.borrow) begin
          // A slice that ends exactly at the ring size sends the head back to zero.
          head_next    = (ht_ge_r && alu_rsp.zero) ? '0 : end_r[OFFSET_BITS-1:0];
          granted_next = 1'b1;
          offset_next  = off_r[OFFSET_BITS-1:0];
        end
      end
      S_A_WRAP: begin
        alu_req.sub = 1'b1;
        alu_req.a   = ALU_W'(tail);
        alu_req.b   = ALU_W'(size_r);
        if (!alu_rsp.borrow) begin
          head_next    = size_r[OFFSET_BITS-1:0];
          granted_next = 1'b1;
          offset_next  = '0;
        end
      end
      S_R_CMP: begin
        alu_req.sub = 1'b1;
        alu_req.a   = ALU_W'(t_r);
        alu_req.b   = ALU_W'(cap);
        if (alu_rsp.borrow) begin
          tail_next = t_r;
        end else begin
          rem_next = '0;
          cnt_next = '0;
        end
      end
      S_R_DIV: begin
        // Restoring remainder, one dividend bit per cycle, MSB first.
        alu_req.sub = 1'b1;
        alu_req.a   = ALU_W'(div_shift);
        alu_req.b   = ALU_W'(cap);
        rem_next    = alu_rsp.borrow ? div_shift[OFFSET_BITS-1:0]
                                     : alu_rsp.res[OFFSET_BITS-1:0];
        t_next      = t_r << 1;
        cnt_next    = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_LAST) begin
          tail_next = rem_next;
        end
      end
      S_U_HT: begin
        alu_req.sub = 1'b1;
        alu_req.a   = ALU_W'(head);
        alu_req.b   = ALU_W'(tail);
        if (!alu_rsp.borrow) begin
          used_next = alu_rsp.res[CAP_W-1:0];
        end
      end
      S_U_WRAP: begin
        alu_req.sub = 1'b1;
        alu_req.a   = ALU_W'(cap);
        alu_req.b   = ALU_W'(tail);
        used_next   = alu_rsp.res[CAP_W-1:0];
      end
      S_U_ADD: begin
        alu_req.a = ALU_W'(used_r);
        alu_req.b = ALU_W'(head);
        used_next = alu_rsp.res[CAP_W-1:0];
      end
      S_FREE: begin
        alu_req.sub = 1'b1;
        alu_req.a   = ALU_W'(cap);
        alu_req.b   = ALU_W'(used_r);
        free_next   = alu_rsp.borrow ? '0 : alu_rsp.res[CAP_W-1:0];
      end
      S_OUT: begin
        rsp_load = !rsp_valid || rsp.ready;
      end
      default: begin
        rsp_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      tail      <= '0;
      rsp_valid <= 1'b0;
      for (int i = 0; i < FRAME_SLOTS; i++) begin
        slot_end[i] <= '0;
      end
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      if (record_wr) begin
        slot_end[idx_in] <= head;
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    size_r    <= size_next;
    am1_r     <= am1_next;
    off_r     <= off_next;
    end_r     <= end_next;
    ht_ge_r   <= ht_ge_next;
    t_r       <= t_next;
    rem_r     <= rem_next;
    cnt_r     <= cnt_next;
    used_r    <= used_next;
    free_r    <= free_next;
    granted_r <= granted_next;
    offset_r  <= offset_next;
    if (rsp_load) begin
      rsp.granted      <= granted_r;
      rsp.slice_offset <= offset_r;
      rsp.used_bytes   <= used_r;
      rsp.free_bytes   <= free_r;
      rsp.ring_empty   <= empty_flag;
    end
  end

  assign rsp.valid = rsp_valid;

endmodule

@@ hw/rtl/frame_fenced_ring_allocator.sv @@
// Top level of the frame-fenced ring allocator: capacity register, sequencer, shared unit.
// Depends on ffra_pkg, ffra_req_if, ffra_rsp_if, ffra_alu and ffra_seq.
//
//   Channel  Dir  Handshake             Carries
//   req      in   valid/ready           opcode, request_size, align_bytes, frame_slot
//   rsp      out  valid/ready           granted, slice_offset, used_bytes, free_bytes,
//                                       ring_empty
//   cfg      in   cfg_wr_en, no stall   cfg_wr_data = ring_capacity
//
// Each transaction runs through a small sequencer that issues one operation per cycle to a
// single shared add/subtract unit, and issues none while it waits on a full result register.
// An allocate checks the size, aligns the offset, finds the end and tests the fit, and skips
// the fit steps when its size is zero or too large; a release adds a bit-serial remainder when
// its recorded end is at or past the capacity. A request is taken only while the sequencer
// is idle, also while the previous result still waits; a full result register stalls it.
// Reset (rst, synchronous) clears head, tail, all slot ends and sets the capacity to 2^24.
module frame_fenced_ring_allocator #(
  parameter int FRAME_SLOTS = ffra_pkg::DEFAULT_FRAME_SLOTS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [ffra_pkg::CAP_W-1:0] cfg_wr_data,
  ffra_req_if.sink                   req,
  ffra_rsp_if.source                 rsp
);
  import ffra_pkg::*;

  // The capacity is held already clamped to its usable range: zero acts as one and
  // anything above the offset space acts as the full offset space.
  logic [CAP_W-1:0] cap;
  logic [CAP_W-1:0] cap_next;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  always_comb begin
    if (cfg_wr_data == '0) begin
      cap_next = CAP_W'(1);
    end else if (cfg_wr_data > CAP_MAX) begin
      cap_next = CAP_MAX;
    end else begin
      cap_next = cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= CAP_RESET;
    end else if (cfg_wr_en) begin
      cap <= cap_next;
    end
  end

  // The shared unit carries the adds, subtracts and compares on offsets, sizes and capacity.
  ffra_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // Sequencer owns the ring pointers, the slot ends and the result register.
  ffra_seq #(
    .FRAME_SLOTS (FRAME_SLOTS)
  ) u_seq (
    .clk     (clk),
    .rst     (rst),
    .cap     (cap),
    .req     (req),
    .rsp     (rsp),
    .alu_req (alu_req),
    .alu_rsp (alu_rsp)
  );

endmodule

@@ bench/frame_fenced_ring_allocator_test.sv @@
// Self-checking testbench of the frame-fenced ring allocator.
// Depends on ffra_pkg, ffra_req_if, ffra_rsp_if and the frame_fenced_ring_allocator RTL.
module frame_fenced_ring_allocator_test;
  import ffra_pkg::*;

  localparam int FRAME_SLOTS = DEFAULT_FRAME_SLOTS;
  // Random transactions per capacity setting, and the number of settings.
  localparam int PHASE_ITEMS = 160;
  localparam int PHASES = 10;
  // The slowest transaction is a release that needs the remainder; this many quiet cycles
  // after the last result is enough for the block to go idle.
  localparam int SETTLE_CYCLES = 40;
  // Length of the long receiver hold-off that backs the block up into its input.
  localparam int LONG_HOLD = 400;
  // Cycles without any accepted transaction before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int REPORT_LIMIT = 10;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  typedef struct packed {
    op_t               opcode;
    logic [SIZE_W-1:0] request_size;
    logic [SIZE_W-1:0] align_bytes;
    logic [SLOT_W-1:0] frame_slot;
  } ring_req_t;

  typedef struct packed {
    logic                   granted;
    logic [OFFSET_BITS-1:0] slice_offset;
    logic [CAP_W-1:0]       used_bytes;
    logic [CAP_W-1:0]       free_bytes;
    logic                   ring_empty;
  } ring_grant_t;

  // Scoreboard: an independent copy of the ring state, the grants it predicts for every
  // accepted request, and the comparison against what the block returns.
  class ring_ledger;
    logic [CAP_W-1:0]       capacity_reg;
    logic [OFFSET_BITS-1:0] head;
    logic [OFFSET_BITS-1:0] tail;
    logic [OFFSET_BITS-1:0] slot_end [FRAME_SLOTS];
    ring_grant_t            awaited_grants [$];
    int                     mismatches;

    function new();
      capacity_reg = CAP_RESET;
      head = '0;
      tail = '0;
      foreach (slot_end[i]) slot_end[i] = '0;
      mismatches = 0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] value);
      capacity_reg = value;
    endfunction

    // Zero behaves as one byte; anything above 2^OFFSET_BITS is clipped.
    function longint unsigned effective_capacity();
      if (capacity_reg == 0) return 1;
      if (capacity_reg > CAP_MAX) return CAP_MAX;
      return capacity_reg;
    endfunction

    function int outstanding();
      return awaited_grants.size();
    endfunction

    function bit clean();
      return mismatches == 0 && awaited_grants.size() == 0;
    endfunction

    // Applies one request to the ring state and returns the grant it should produce.
    function ring_grant_t grant_for(ring_req_t r);
      ring_grant_t     g;
      longint unsigned cap;
      longint unsigned a;
      longint unsigned off;
      longint unsigned fin;
      longint unsigned t;
      longint unsigned used;
      bit              ok;
      bit              empty;
      cap = effective_capacity();
      off = 0;
      ok = 1'b0;
      case (r.opcode)
        OP_ALLOC: begin
          a = (r.align_bytes == 0) ? DEFAULT_ALIGN : r.align_bytes;
          if (r.request_size != 0 && r.request_size <= cap) begin
            off = (head + a - 1) & ~(a - 1);
            fin = off + r.request_size;
            if (head >= tail) begin
              if (fin <= cap) begin
                // A slice that ends exactly at the capacity sends the head back to 0.
                head = (fin == cap) ? '0 : fin[OFFSET_BITS-1:0];
                ok = 1'b1;
              end else if (r.request_size <= tail) begin
                head = r.request_size[OFFSET_BITS-1:0];
                off = 0;
                ok = 1'b1;
              end
            end else if (fin <= tail) begin
              head = fin[OFFSET_BITS-1:0];
              ok = 1'b1;
            end
          end
          if (!ok) off = 0;
        end
        OP_RECORD: begin
          if (r.frame_slot < FRAME_SLOTS) begin
            slot_end[r.frame_slot] = head;
            ok = 1'b1;
          end
        end
        OP_RELEASE: begin
          if (r.frame_slot < FRAME_SLOTS) begin
            // An end recorded under a larger capacity is folded back into the ring.
            t = slot_end[r.frame_slot];
            if (t >= cap) t = t % cap;
            tail = t[OFFSET_BITS-1:0];
            ok = 1'b1;
          end
        end
        default: ;
      endcase

      if (head == tail) used = 0;
      else if (head > tail) used = head - tail;
      else used = (cap - tail + head) & ((64'd1 << CAP_W) - 1);
      empty = (head == tail);
      foreach (slot_end[i]) if (slot_end[i] != tail) empty = 1'b0;

      g.granted = ok;
      g.slice_offset = off[OFFSET_BITS-1:0];
      g.used_bytes = used[CAP_W-1:0];
      g.free_bytes = (used >= cap) ? '0 : CAP_W'(cap - used);
      g.ring_empty = empty;
      return g;
    endfunction

    function void note_request(ring_req_t r);
      awaited_grants.push_back(grant_for(r));
    endfunction

    function void check_result(ring_grant_t got);
      ring_grant_t want;
      if (awaited_grants.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result: granted=%0d offset=%0d used=%0d free=%0d empty=%0d",
                   got.granted, got.slice_offset, got.used_bytes, got.free_bytes,
                   got.ring_empty);
        return;
      end
      want = awaited_grants.pop_front();
      if (got.granted !== want.granted || got.slice_offset !== want.slice_offset ||
          got.used_bytes !== want.used_bytes || got.free_bytes !== want.free_bytes ||
          got.ring_empty !== want.ring_empty) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("result mismatch at %0t", $realtime);
          $display("  expected granted=%0d offset=%0d used=%0d free=%0d empty=%0d",
                   want.granted, want.slice_offset, want.used_bytes, want.free_bytes,
                   want.ring_empty);
          $display("  actual   granted=%0d offset=%0d used=%0d free=%0d empty=%0d",
                   got.granted, got.slice_offset, got.used_bytes, got.free_bytes,
                   got.ring_empty);
        end
      end
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             cfg_wr_en;
  logic [CAP_W-1:0] cfg_wr_data;

  ffra_req_if req_ch();
  ffra_rsp_if rsp_ch();

  frame_fenced_ring_allocator u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .req        (req_ch),
    .rsp        (rsp_ch)
  );

  ring_ledger ledger;

  // Idle and stall rates in percent, changed by the stimulus between phases.
  int send_idle_pct = 0;
  int rsp_stall_pct = 0;
  // Set by the stimulus to make the receiver start one long hold-off.
  bit rsp_hold_request = 1'b0;
  // Running frame number; its low bits select the slot of each frame.
  int frame_no = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic ring_req_t make_req(op_t op, logic [SIZE_W-1:0] size,
                                         logic [SIZE_W-1:0] align, int slot);
    ring_req_t r;
    r.opcode = op;
    r.request_size = size;
    r.align_bytes = align;
    r.frame_slot = SLOT_W'(slot);
    return r;
  endfunction

  // Sizes are mostly scaled to the current ring so that it fills and wraps, with zero,
  // exact-fit, oversize and raw 25-bit values mixed in.
  function automatic logic [SIZE_W-1:0] pick_size();
    longint unsigned cap;
    int              lg;
    cap = ledger.effective_capacity();
    lg = $clog2(cap);
    case ($urandom_range(15))
      0: return '0;
      1: return SIZE_W'($urandom);
      2: return SIZE_W'(cap);
      3: return SIZE_W'(cap + 1);
      4, 5, 6: return SIZE_W'(1) << $urandom_range(0, (lg > 2) ? lg - 2 : 0);
      default: return SIZE_W'(1 + $urandom_range(32'(cap >> $urandom_range(2, 5))));
    endcase
  endfunction

  // Alignments: mostly small powers of two, sometimes the default, any power up to
  // bit 24, or a raw random value that is seldom a power of two.
  function automatic logic [SIZE_W-1:0] pick_align();
    case ($urandom_range(9))
      0: return '0;
      1: return SIZE_W'($urandom);
      2: return SIZE_W'(1) << $urandom_range(0, SIZE_W - 1);
      default: return SIZE_W'(1) << $urandom_range(0, 6);
    endcase
  endfunction

  task automatic set_idling(idle_mode_t mode);
    send_idle_pct = (mode == IDLE_SENDER) ? 74 : (mode == IDLE_BOTH) ? 17 : 0;
    rsp_stall_pct = (mode == IDLE_RECEIVER) ? 74 : (mode == IDLE_BOTH) ? 17 : 0;
  endtask

  // Offers one request transaction and returns at the edge where it is accepted. The
  // request is noted in the ledger right here, so the count of outstanding grants is
  // always current when the stimulus looks at it.
  task automatic offer_request(ring_req_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.opcode <= item.opcode;
    req_ch.request_size <= item.request_size;
    req_ch.align_bytes <= item.align_bytes;
    req_ch.frame_slot <= item.frame_slot;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    ledger.note_request(item);
  endtask

  // The sender stops, waits for every outstanding grant and then lets the sequencer
  // finish whatever it may still be doing.
  task automatic settle();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (ledger.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    ledger.set_capacity(value);
  endtask

  // Most traffic is whole frames: a few allocations, a record of the frame end in this
  // frame's slot and a release of a slot one to three frames back, so the tail chases
  // the head and the ring wraps. The rest is unstructured noise, unused opcodes included.
  task automatic run_traffic(int count);
    int issued;
    int n;
    issued = 0;
    while (issued < count) begin
      if ($urandom_range(99) < 80) begin
        n = $urandom_range(1, 6);
        repeat (n)
          offer_request(make_req(OP_ALLOC, pick_size(), pick_align(), $urandom_range(7)));
        offer_request(make_req(OP_RECORD, SIZE_W'($urandom), SIZE_W'($urandom),
                               frame_no % FRAME_SLOTS));
        offer_request(make_req(OP_RELEASE, SIZE_W'($urandom), SIZE_W'($urandom),
                               (frame_no + FRAME_SLOTS - $urandom_range(1, 3)) % FRAME_SLOTS));
        frame_no++;
        issued += n + 2;
      end else begin
        offer_request(make_req(op_t'($urandom_range(3)), pick_size(), pick_align(),
                               $urandom_range(7)));
        issued++;
      end
    end
  endtask

  function automatic logic [CAP_W-1:0] phase_capacity(int ph);
    case (ph)
      1: return CAP_W'(4096);
      2: return CAP_W'(1000);
      3: return CAP_W'(64);
      4: return CAP_W'(1);
      5: return '0;
      6: return '1;
      7: return CAP_MAX;
      8: return CAP_W'(777);
      9: return CAP_W'(12345678);
      default: return CAP_RESET;
    endcase
  endfunction

  // Receiver: checks every accepted result transaction and drives ready. A hold-off
  // request from the stimulus keeps ready low while hold counts down from LONG_HOLD.
  initial begin : receiver
    int           hold;
    ring_grant_t  got;
    hold = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid && rsp_ch.ready) begin
        got.granted = rsp_ch.granted;
        got.slice_offset = rsp_ch.slice_offset;
        got.used_bytes = rsp_ch.used_bytes;
        got.free_bytes = rsp_ch.free_bytes;
        got.ring_empty = rsp_ch.ring_empty;
        ledger.check_result(got);
      end
      if (rsp_hold_request) begin
        rsp_hold_request = 1'b0;
        hold = LONG_HOLD;
      end
      if (hold > 0) begin
        hold--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
    end
  end

  // Watchdog: ends the run if no transaction moves on either channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    ledger = new();
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    req_ch.valid = 1'b0;
    req_ch.opcode = OP_ALLOC;
    req_ch.request_size = '0;
    req_ch.align_bytes = '0;
    req_ch.frame_slot = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed walk at the reset capacity of 2^24 bytes, fully back to back. The offsets
    // in the comments follow from the requests before them.
    set_idling(IDLE_NONE);
    offer_request(make_req(OP_ALLOC, '0, '0, 0));                    // zero size fails
    offer_request(make_req(OP_ALLOC, SIZE_W'(CAP_MAX) + SIZE_W'(1), '0, 0)); // one too many
    offer_request(make_req(OP_ALLOC, '1, '1, 7));                    // all bits set
    offer_request(make_req(OP_ALLOC, 25'd100, '0, 0));               // default alignment
    offer_request(make_req(OP_ALLOC, 25'd8, 25'd24, 0));             // non-power-of-two mask
    offer_request(make_req(OP_ALLOC, 25'd1, SIZE_W'(CAP_MAX), 0));   // no room, no wrap
    offer_request(make_req(OP_RECORD, '0, '0, 0));                   // slot 0 ends at 112
    offer_request(make_req(OP_ALLOC, 25'd8000000, 25'd1, 0));
    offer_request(make_req(OP_RECORD, '1, '1, 1));                   // slot 1 ends at 8000112
    offer_request(make_req(OP_RELEASE, '0, '0, 0));                  // tail moves to 112
    offer_request(make_req(OP_ALLOC, 25'd8777000, 25'd1, 0));
    offer_request(make_req(OP_ALLOC, 25'd104, 25'd1, 0));            // ends at capacity
    offer_request(make_req(OP_ALLOC, 25'd200, '0, 0));               // would overrun tail
    offer_request(make_req(OP_ALLOC, 25'd112, 25'd1, 0));            // head meets tail
    offer_request(make_req(OP_RECORD, '0, '0, 2));                   // slot 2 ends at 112
    offer_request(make_req(OP_RELEASE, '0, '0, 1));                  // head behind tail
    offer_request(make_req(OP_ALLOC, 25'd8000000, 25'd1, 0));
    offer_request(make_req(OP_RELEASE, '0, '0, 2));
    offer_request(make_req(OP_ALLOC, 25'd9000000, 25'd1, 0));        // too big to wrap
    offer_request(make_req(OP_ALLOC, 25'd100, SIZE_W'(CAP_MAX), 0)); // wraps to offset 0
    offer_request(make_req(OP_RELEASE, '1, '1, 7));                  // never recorded slot
    offer_request(make_req(OP_NOP, '1, '1, 7));                      // unused opcode
    settle();

    // Random phases, each under its own capacity and idling pattern. Capacities change
    // with the ring state left as it is, which exercises the folded release and the
    // oversized used count. Every write is made once the block has gone quiet.
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph != 0) write_capacity(phase_capacity(ph));
      set_idling(idle_mode_t'(ph % 4));
      // In the phases without idling the receiver also holds off for a long stretch
      // while requests keep coming, so the block backs up and stalls its input.
      if (ph % 4 == 0) rsp_hold_request = 1'b1;
      run_traffic(PHASE_ITEMS);
      settle();
    end

    if (ledger.clean()) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
